// ===== design/rct_pkg.sv =====
package rct_pkg;

  localparam int ENTRIES    = 16;
  localparam int ADDR_BITS  = 32;
  localparam int COUNT_BITS = 16;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ENTRIES-1:0]    ent_vec_t;

  localparam count_t COUNT_ONE = count_t'(1);
  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    KIND_REGISTER = 1'b0,
    KIND_ASSIGN   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_UNTRACKED = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } rct_cmd_t;

endpackage

// ===== design/rct_ctrl.sv =====
module rct_ctrl import rct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rct_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.exec  = (state_q == ST_EXEC);

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("controller state not one-hot");

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec) else $error("accepted transfer not executed");

  a_exec_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o && !in_ready_o) else $error("result not presented");
`endif

endmodule

// ===== design/rct_dp.sv =====
module rct_dp import rct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rct_cmd_t   cmd_i,
  input  logic       kind_i,
  input  addr_t      old_address_i,
  input  addr_t      new_address_i,
  output logic [1:0] status_o,
  output logic       released_o,
  output addr_t      released_address_o,
  output count_t     old_count_o,
  output count_t     new_count_o
);

  logic     kind_q;
  addr_t    old_q, new_q;

  ent_vec_t valid_q, valid_d;
  addr_t    addr_q [ENTRIES];
  addr_t    addr_d [ENTRIES];
  count_t   cnt_q  [ENTRIES];
  count_t   cnt_d  [ENTRIES];

  ent_vec_t hit_old, hit_new, free_oh, not_valid, reg_sel;
  logic     old_any, new_any, rel;
  count_t   cur_old_cnt, res_old_cnt, res_new_cnt;
  status_e  status;

  logic [1:0] status_q;
  logic       released_q;
  addr_t      rel_addr_q;
  count_t     old_cnt_q, new_cnt_q;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_old[i] = valid_q[i] && (addr_q[i] == old_q);
      hit_new[i] = valid_q[i] && (addr_q[i] == new_q);
    end
    not_valid = ~valid_q;
    free_oh   = not_valid & (~not_valid + ent_vec_t'(1));
    old_any   = |hit_old;
    new_any   = |hit_new;
    reg_sel   = old_any ? hit_old : free_oh;

    cur_old_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cur_old_cnt = cur_old_cnt | (cnt_q[i] & {COUNT_BITS{hit_old[i]}});
    end
    rel = (kind_q == KIND_ASSIGN) && old_any && (cur_old_cnt <= COUNT_ONE);

    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i] = valid_q[i];
      addr_d[i]  = addr_q[i];
      cnt_d[i]   = cnt_q[i];
      if (kind_q == KIND_REGISTER) begin
        if (reg_sel[i]) begin
          valid_d[i] = 1'b1;
          addr_d[i]  = old_q;
          cnt_d[i]   = COUNT_ONE;
        end
      end else if (hit_old[i]) begin
        if (rel) begin
          valid_d[i] = 1'b0;
          cnt_d[i]   = '0;
        end else if (!hit_new[i]) begin
          cnt_d[i] = cnt_q[i] - COUNT_ONE;
        end
      end else if (hit_new[i]) begin
        if (cnt_q[i] != COUNT_MAX) cnt_d[i] = cnt_q[i] + COUNT_ONE;
      end
    end

    res_old_cnt = '0;
    res_new_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      res_old_cnt = res_old_cnt | (cnt_d[i] & {COUNT_BITS{hit_old[i]}});
      res_new_cnt = res_new_cnt | (cnt_d[i] & {COUNT_BITS{hit_new[i]}});
    end

    if (kind_q == KIND_REGISTER) begin
      status      = (|reg_sel) ? STATUS_OK : STATUS_FULL;
      res_old_cnt = (|reg_sel) ? COUNT_ONE : '0;
      res_new_cnt = '0;
    end else begin
      status = (old_any && new_any) ? STATUS_OK : STATUS_UNTRACKED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      old_q  <= old_address_i;
      new_q  <= new_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < ENTRIES; i++) begin
        addr_q[i] <= addr_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
      status_q   <= status;
      released_q <= rel;
      rel_addr_q <= rel ? old_q : '0;
      old_cnt_q  <= res_old_cnt;
      new_cnt_q  <= res_new_cnt;
    end
  end

  assign status_o           = status_q;
  assign released_o         = released_q;
  assign released_address_o = rel_addr_q;
  assign old_count_o        = old_cnt_q;
  assign new_count_o        = new_cnt_q;

`ifndef SYNTHESIS
  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && rel |=> released_o && (old_count_o == '0))
    else $error("released entry reports nonzero count");

  a_full_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (status == STATUS_FULL) |=> !released_o && (valid_q == '1))
    else $error("full status with free entry or release");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> $onehot0(hit_old) && $onehot0(hit_new))
    else $error("address tracked in more than one entry");
`endif

endmodule

// ===== design/reference_count_table_top.sv =====
// An accepted item moves from idle to the execute state and then to the done state,
// where the result is held valid until the output side takes it; only then does the
// controller accept a new item, handling accept, execute, present one item at a time.
// Each item compares both addresses against all 16 entries in the execute state.
// Reset (rst_ni low, asynchronous) clears all entry valid bits and idles the controller.
module reference_count_table_top import rct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  addr_t      old_address_i,
  input  addr_t      new_address_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       released_o,
  output addr_t      released_address_o,
  output count_t     old_count_o,
  output count_t     new_count_o
);

  rct_cmd_t cmd;

  rct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rct_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .kind_i             (kind_i),
    .old_address_i      (old_address_i),
    .new_address_i      (new_address_i),
    .status_o           (status_o),
    .released_o         (released_o),
    .released_address_o (released_address_o),
    .old_count_o        (old_count_o),
    .new_count_o        (new_count_o)
  );

endmodule
